FILE: design/tournament_hamiltonian_path_counter_assert.svh
`ifndef TOURNAMENT_HAMILTONIAN_PATH_COUNTER_ASSERT_SVH
`define TOURNAMENT_HAMILTONIAN_PATH_COUNTER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define THPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define THPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/thpc_pkg.sv
`timescale 1ns / 1ps

package thpc_pkg;

   // Default vertex count and fixed field widths
   localparam int VERTICES_DEFAULT = 11;
   localparam int EDGE_W           = 55;
   localparam int COUNT_W          = 32;

endpackage

FILE: design/tournament_hamiltonian_path_counter.sv
`timescale 1ns / 1ps

// Tournament Hamiltonian path counter.
// Input channel (req_valid/req_ready, req_edge_bits): one item is a whole tournament,
// bit e orienting the e-th vertex pair in row-major order (1: lower vertex wins).
// Result channel (rsp_valid/rsp_ready): one item per input, rsp_strongly_connected
// and rsp_path_count (Hamiltonian paths modulo 2^32, zero when not strongly connected).
// Processing: forward and backward reachability from vertex 0, then, for a strong
// tournament, the subset DP visits each (vertex set, end vertex) pair in PICK, SCAN
// and WRITE, with an extra PICK step for each set that lacks the highest vertex; then
// FINISH, and DONE loads the result register. Run time is set by the single read port
// of the path-count memory, which scans one predecessor per cycle for each pair.
// One item is processed at a time; req_ready is high only while the block is idle.
// The result sits in an output register, so the block takes the next item while the
// receiver stalls; it then holds that item's result until the register frees up.
// Reset (synchronous, active high) returns the block to idle with no result pending.
// The count memory needs no clearing: every entry read was written earlier in the
// same item.

module tournament_hamiltonian_path_counter
   import thpc_pkg::*;
#(
   parameter int VERTICES = VERTICES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [EDGE_W-1:0]  req_edge_bits,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_strongly_connected,
   output logic [COUNT_W-1:0] rsp_path_count
);

   localparam int VW    = $clog2(VERTICES);
   localparam int AW    = VERTICES + VW;
   localparam int DEPTH = 1 << AW;
   localparam logic [VERTICES-1:0] FULL_SET = {VERTICES{1'b1}};
   localparam logic [VERTICES-1:0] ONE_SET  = VERTICES'(1);
   localparam logic [VW-1:0]       LAST_V   = VW'(VERTICES - 1);
   localparam logic [VW-1:0]       LAST_IT  = VW'(VERTICES - 2);

   typedef enum logic [2:0] {
      IDLE,
      REACH,
      PICK,
      SCAN,
      WRITE,
      FINISH,
      DONE
   } state_type;

   state_type            state_ff;
   logic [EDGE_W-1:0]    edges_ff;
   logic [VERTICES-1:0]  fwd_ff;
   logic [VERTICES-1:0]  bwd_ff;
   logic [VW-1:0]        it_ff;
   logic [VERTICES-1:0]  mask_ff;
   logic [VW-1:0]        v_ff;
   logic [VW-1:0]        p_ff;
   logic [COUNT_W-1:0]   acc_ff;
   logic                 pend_ff;
   logic [COUNT_W-1:0]   wval_ff;
   logic                 tot_pend_ff;
   logic [COUNT_W-1:0]   total_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_strong_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [COUNT_W-1:0]   rd_data_ff;

   // Path counts per (vertex set, end vertex)
   logic [COUNT_W-1:0]   count_mem [DEPTH];

   logic [VERTICES-1:0]  out_adj [VERTICES];
   logic [VERTICES-1:0]  in_adj  [VERTICES];
   logic [VERTICES-1:0]  fwd_step;
   logic [VERTICES-1:0]  bwd_step;
   logic                 both_reach;
   logic [VERTICES-1:0]  cand;
   logic                 cand_found;
   logic [VW-1:0]        cand_v;
   logic [VERTICES-1:0]  rest;
   logic [VERTICES-1:0]  rest_pick;
   logic [VERTICES-1:0]  choices;
   logic                 issue;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 wr_en;
   logic [COUNT_W-1:0]   rd_term;
   logic [COUNT_W-1:0]   wval;
   logic                 load_rsp;

   // Adjacency masks from the orientation bits
   always_comb begin
      int e;
      e = 0;
      for (int l = 0; l < VERTICES; l++) begin
         out_adj[l] = '0;
         in_adj[l]  = '0;
      end
      for (int l = 0; l < VERTICES; l++) begin
         for (int r = l + 1; r < VERTICES; r++) begin
            out_adj[l][r] = edges_ff[e];
            in_adj[r][l]  = edges_ff[e];
            out_adj[r][l] = ~edges_ff[e];
            in_adj[l][r]  = ~edges_ff[e];
            e = e + 1;
         end
      end
   end

   // One reachability step in each direction
   always_comb begin
      fwd_step = fwd_ff;
      bwd_step = bwd_ff;
      for (int v = 0; v < VERTICES; v++) begin
         if (fwd_ff[v]) begin
            fwd_step = fwd_step | out_adj[v];
         end
         if (bwd_ff[v]) begin
            bwd_step = bwd_step | in_adj[v];
         end
      end
   end

   assign both_reach = (&fwd_step) && (&bwd_step);

   // Next end vertex in the current set, at or above v_ff
   always_comb begin
      cand       = mask_ff & ~((ONE_SET << v_ff) - ONE_SET);
      cand_found = |cand;
      cand_v     = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            cand_v = VW'(i);
         end
      end
   end

   assign rest_pick = mask_ff ^ (ONE_SET << cand_v);
   assign rest      = mask_ff ^ (ONE_SET << v_ff);
   assign choices   = rest & in_adj[v_ff];
   assign issue     = (state_ff == SCAN) && choices[p_ff];
   assign rd_addr   = {rest, p_ff};
   assign wr_addr   = {mask_ff, v_ff};
   assign wr_en     = (state_ff == WRITE);
   assign rd_term   = pend_ff ? rd_data_ff : '0;
   assign wval      = acc_ff + rd_term;
   assign load_rsp  = (state_ff == DONE) && (!rsp_valid_ff || rsp_ready);

   // Count memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wval;
      end
      rd_data_ff <= count_mem[rd_addr];
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pend_ff      <= 1'b0;
         tot_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff     <= issue;
         tot_pend_ff <= (state_ff == WRITE) && (mask_ff == FULL_SET);
         if (tot_pend_ff) begin
            total_ff <= total_ff + wval_ff;
         end
         if (load_rsp) begin
            rsp_valid_ff  <= 1'b1;
            rsp_strong_ff <= (total_ff != '0) || (mask_ff == FULL_SET);
            rsp_count_ff  <= total_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  edges_ff <= req_edge_bits;
                  fwd_ff   <= ONE_SET;
                  bwd_ff   <= ONE_SET;
                  it_ff    <= '0;
                  total_ff <= '0;
                  mask_ff  <= '0;
                  state_ff <= REACH;
               end
            end
            REACH: begin
               fwd_ff <= fwd_step;
               bwd_ff <= bwd_step;
               it_ff  <= it_ff + 1'b1;
               if (it_ff == LAST_IT) begin
                  if (both_reach) begin
                     mask_ff  <= ONE_SET;
                     v_ff     <= '0;
                     state_ff <= PICK;
                  end else begin
                     state_ff <= DONE;
                  end
               end
            end
            PICK: begin
               if (cand_found) begin
                  v_ff     <= cand_v;
                  p_ff     <= '0;
                  acc_ff   <= (rest_pick == '0) ? COUNT_W'(1) : '0;
                  state_ff <= SCAN;
               end else if (mask_ff == FULL_SET) begin
                  state_ff <= FINISH;
               end else begin
                  mask_ff <= mask_ff + ONE_SET;
                  v_ff    <= '0;
               end
            end
            SCAN: begin
               acc_ff <= wval;
               p_ff   <= p_ff + 1'b1;
               if (p_ff == LAST_V) begin
                  state_ff <= WRITE;
               end
            end
            WRITE: begin
               wval_ff <= wval;
               if (v_ff != LAST_V) begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= PICK;
               end else if (mask_ff == FULL_SET) begin
                  state_ff <= FINISH;
               end else begin
                  mask_ff  <= mask_ff + ONE_SET;
                  v_ff     <= '0;
                  state_ff <= PICK;
               end
            end
            FINISH: begin
               state_ff <= DONE;
            end
            DONE: begin
               if (load_rsp) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_ready              = (state_ff == IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_strongly_connected = rsp_strong_ff;
   assign rsp_path_count         = rsp_count_ff;

endmodule

FILE: design/thpc_checker.sv
`timescale 1ns / 1ps

`include "tournament_hamiltonian_path_counter_assert.svh"

module thpc_checker
   import thpc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_strongly_connected,
   input logic [COUNT_W-1:0] rsp_path_count
);

   // A stalled result stays offered
   `THPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")

   // A stalled result keeps its count and connectivity flag
   `THPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_path_count) && $stable(rsp_strongly_connected), "result item changed while stalled")

   // No paths reported for a tournament that is not strongly connected
   `THPC_ASSERT_NOW(a_weak_zero, clock, reset, rsp_valid && !rsp_strongly_connected, rsp_path_count == '0, "nonzero count without strong connectivity")

   // One item at a time: busy right after an accepted item
   `THPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

endmodule

bind tournament_hamiltonian_path_counter thpc_checker u_thpc_checker (.*);

FILE: dv/tournament_hamiltonian_path_counter_tb.sv
`timescale 1ns / 1ps

import thpc_pkg::*;

// One result item: strong-connectivity flag and Hamiltonian path count
typedef struct packed {
   logic               connected;
   logic [COUNT_W-1:0] count;
} path_result_type;

// Predicts the path count per tournament and checks result items in order
class path_count_scoreboard;
   path_result_type               expected_results [$];
   int unsigned                   mismatches;
   bit [VERTICES_DEFAULT-1:0]     outgoing [VERTICES_DEFAULT];
   bit [VERTICES_DEFAULT-1:0]     incoming [VERTICES_DEFAULT];
   bit [COUNT_W-1:0]              ending_counts [(1 << VERTICES_DEFAULT) * VERTICES_DEFAULT];

   function new();
      mismatches = 0;
   endfunction

   // Closure from vertex 0 along out-edges (forward) or in-edges (backward)
   function bit reaches_everyone(input bit backward);
      bit [VERTICES_DEFAULT-1:0] seen;
      bit [VERTICES_DEFAULT-1:0] prev;
      seen = VERTICES_DEFAULT'(1);
      prev = '0;
      while (seen != prev) begin
         prev = seen;
         for (int v = 0; v < VERTICES_DEFAULT; v++) begin
            if (seen[v]) begin
               seen |= backward ? incoming[v] : outgoing[v];
            end
         end
      end
      return &seen;
   endfunction

   function path_result_type count_paths(input logic [EDGE_W-1:0] bits);
      path_result_type  res;
      int               e;
      int               rest;
      bit               is_strong;
      bit [COUNT_W-1:0] acc;
      bit [COUNT_W-1:0] total;
      // adjacency masks; pairs in row-major order, 1 = lower vertex wins
      for (int v = 0; v < VERTICES_DEFAULT; v++) begin
         outgoing[v] = '0;
         incoming[v] = '0;
      end
      e = 0;
      for (int l = 0; l < VERTICES_DEFAULT; l++) begin
         for (int r = l + 1; r < VERTICES_DEFAULT; r++) begin
            if (e < EDGE_W && bits[e]) begin
               outgoing[l][r] = 1'b1;
               incoming[r][l] = 1'b1;
            end else begin
               outgoing[r][l] = 1'b1;
               incoming[l][r] = 1'b1;
            end
            e++;
         end
      end
      is_strong = reaches_everyone(1'b0) && reaches_everyone(1'b1);
      total     = '0;
      // subset DP over (vertex set, end vertex), sums wrap at 32 bits
      if (is_strong) begin
         for (int v = 0; v < VERTICES_DEFAULT; v++) begin
            ending_counts[(1 << v) * VERTICES_DEFAULT + v] = COUNT_W'(1);
         end
         for (int mask = 1; mask < (1 << VERTICES_DEFAULT); mask++) begin
            for (int v = 0; v < VERTICES_DEFAULT; v++) begin
               if (!mask[v]) continue;
               rest = mask ^ (1 << v);
               if (rest == 0) continue;
               acc = '0;
               for (int p = 0; p < VERTICES_DEFAULT; p++) begin
                  if (rest[p] && incoming[v][p]) begin
                     acc += ending_counts[rest * VERTICES_DEFAULT + p];
                  end
               end
               ending_counts[mask * VERTICES_DEFAULT + v] = acc;
            end
         end
         for (int v = 0; v < VERTICES_DEFAULT; v++) begin
            total += ending_counts[((1 << VERTICES_DEFAULT) - 1) * VERTICES_DEFAULT + v];
         end
      end
      res.connected = is_strong;
      res.count     = is_strong ? total : '0;
      return res;
   endfunction

   function void note_tournament(input logic [EDGE_W-1:0] bits);
      expected_results.push_back(count_paths(bits));
   endfunction

   function void check_result(input logic got_strong, input logic [COUNT_W-1:0] count);
      path_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result item: strong=%0d count=%0d", got_strong, count);
         end
         return;
      end
      want = expected_results.pop_front();
      if (want.connected !== got_strong || want.count !== count) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected strong=%0d count=%0d, got strong=%0d count=%0d",
                     want.connected, want.count, got_strong, count);
         end
      end
   endfunction
endclass

module tournament_hamiltonian_path_counter_tb;

   localparam int          NV          = VERTICES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 80_000_000;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [EDGE_W-1:0]  req_edge_bits = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic               rsp_strongly_connected;
   logic [COUNT_W-1:0] rsp_path_count;

   path_count_scoreboard path_check = new();
   int unsigned          accepted_items = 0;
   int unsigned          cycles = 0;
   int                   hold_left = 400;

   tournament_hamiltonian_path_counter #(
      .VERTICES(NV)
   ) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_edge_bits          (req_edge_bits),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_strongly_connected (rsp_strongly_connected),
      .rsp_path_count         (rsp_path_count)
   );

   always #5 clock = ~clock;

   // no idling on either side through the middle of the run
   function automatic bit quiet_stretch();
      return accepted_items >= 35 && accepted_items < 65;
   endfunction

   // side vertices beat all others: never strongly connected
   function automatic logic [EDGE_W-1:0] split_tournament(input int side,
                                                          input logic [EDGE_W-1:0] fill);
      logic [EDGE_W-1:0] bits;
      int                e;
      bits = '0;
      e    = 0;
      for (int l = 0; l < NV; l++) begin
         for (int r = l + 1; r < NV; r++) begin
            bits[e] = (side[l] == side[r]) ? fill[e] : side[l];
            e++;
         end
      end
      return bits;
   endfunction

   // regular tournament: i beats the next NV/2 vertices around the circle
   function automatic logic [EDGE_W-1:0] circulant_tournament();
      logic [EDGE_W-1:0] bits;
      int                e;
      bits = '0;
      e    = 0;
      for (int l = 0; l < NV; l++) begin
         for (int r = l + 1; r < NV; r++) begin
            bits[e] = (r - l) <= NV / 2;
            e++;
         end
      end
      return bits;
   endfunction

   function automatic logic [EDGE_W-1:0] random_bits();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[EDGE_W-1:0];
   endfunction

   // offer one item at the falling edge, hold until accepted
   task automatic send_item(input logic [EDGE_W-1:0] bits);
      @(negedge clock);
      if (!quiet_stretch()) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_edge_bits <= bits;
      do @(posedge clock); while (!req_ready);
      path_check.note_tournament(bits);
      accepted_items++;
   endtask

   // receiver: long hold-off after reset so the block fills, then random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         if (!reset) hold_left--;
      end else begin
         rsp_ready <= quiet_stretch() || ($urandom_range(99) >= 20);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         path_check.check_result(rsp_strongly_connected, rsp_path_count);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [EDGE_W-1:0] bits;
      int                kind;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: transitive and split tournaments first, they finish fast
      send_item('0);
      send_item('1);
      send_item(split_tournament(1, random_bits()));
      send_item(split_tournament((1 << NV) - 1 - (1 << (NV - 1)), random_bits()));
      send_item(split_tournament($urandom_range(1, (1 << NV) - 2), random_bits()));
      send_item(split_tournament(((1 << NV) - 1) & ~((1 << (NV / 2)) - 1), '0));
      // strong: transitive order closed into a Hamiltonian cycle
      bits         = '1;
      bits[NV - 2] = 1'b0;
      send_item(bits);
      send_item(circulant_tournament());
      send_item(~circulant_tournament());
      send_item(EDGE_W'({(EDGE_W + 1) / 2 {2'b01}}));
      send_item(EDGE_W'({(EDGE_W + 1) / 2 {2'b10}}));
      bits                                = '1;
      bits[$urandom_range(EDGE_W - 1, 0)] = 1'b0;
      send_item(bits);

      // random: uniform, near-transitive, and split tournaments
      repeat (90) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            bits = random_bits();
         end else if (kind < 65) begin
            bits = $urandom_range(1) ? '1 : '0;
            repeat ($urandom_range(4, 1)) bits[$urandom_range(EDGE_W - 1, 0)] ^= 1'b1;
         end else begin
            bits = split_tournament($urandom_range(1, (1 << NV) - 2), random_bits());
         end
         send_item(bits);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then watch for stray results
      while (path_check.expected_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (path_check.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/thpc_pkg.sv
design/tournament_hamiltonian_path_counter.sv
design/thpc_checker.sv
dv/tournament_hamiltonian_path_counter_tb.sv
